// File: hdl/ppf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the polyline path follower.
// ----------------------------------------------------------------------------
package ppf_pkg;

  localparam int DEF_MAX_POINTS = 256;

  localparam int ITER_W     = 6;
  localparam int SQ_LAST    = 3;   // three squares plus one accumulate
  localparam int SQRT_LAST  = 36;  // init plus 36 root bits
  localparam int DIV_LAST   = 16;  // 17 quotient bits
  localparam int LERP_LAST  = 3;

  localparam logic [16:0] SNAP_LIMIT = 17'd64881;

  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_HALF  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic              capture;
    logic              clr_ok;
    logic              mem_wr;
    logic              rd_zero;
    logic              rd_seg;
    logic              rd_seg1;
    logic              start_set;
    logic              stop;
    logic              tick_init;
    logic              cap_a;
    logic              diff;
    logic              sq_en;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              skip;
    logic              trav;
    logic              step;
    logic              div_init;
    logic              div_step;
    logic              div_first;
    logic              lerp;
    logic              update;
    logic              tick_end;
    logic              out_load;
    logic [ITER_W-1:0] iter;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_code_t code;
    logic      total_zero;
    logic      follow;
    logic      go;
    logic      len_zero;
    logic      out_free;
  } dp_status_t;

endpackage

// File: hdl/ppf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_ctrl
// Sequencer: dispatches each item and steps the tick walk through the
// datapath, one segment at a time.
// ----------------------------------------------------------------------------
module ppf_ctrl import ppf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_DISP      = 19'h00002,
    S_START_RD  = 19'h00004,
    S_START_SET = 19'h00008,
    S_TICK_MUL  = 19'h00010,
    S_CHK       = 19'h00020,
    S_RD_A      = 19'h00040,
    S_DIFF      = 19'h00080,
    S_SQ        = 19'h00100,
    S_SQRT      = 19'h00200,
    S_LEN       = 19'h00400,
    S_TRAV      = 19'h00800,
    S_STEP      = 19'h01000,
    S_DIV_INIT  = 19'h02000,
    S_DIV       = 19'h04000,
    S_LERP      = 19'h08000,
    S_UPD       = 19'h10000,
    S_TEND      = 19'h20000,
    S_FIN       = 19'h40000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.iter  = iter_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.clr_ok = 1'b1;
        case (st.code)
          CMD_LOAD: begin
            cmd.mem_wr = 1'b1;
            state_nxt  = S_FIN;
          end
          CMD_START: begin
            if (st.total_zero) begin
              state_nxt = S_FIN;
            end else begin
              cmd.rd_zero = 1'b1;
              state_nxt   = S_START_RD;
            end
          end
          CMD_TICK: state_nxt = st.follow ? S_TICK_MUL : S_FIN;
          default: begin
            cmd.stop  = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_START_RD: state_nxt = S_START_SET;
      S_START_SET: begin
        cmd.start_set = 1'b1;
        state_nxt     = S_FIN;
      end
      S_TICK_MUL: begin
        cmd.tick_init = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (st.go) begin
          cmd.rd_seg = 1'b1;
          state_nxt  = S_RD_A;
        end else begin
          state_nxt = S_TEND;
        end
      end
      S_RD_A: begin
        cmd.cap_a   = 1'b1;
        cmd.rd_seg1 = 1'b1;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        if (iter_r == ITER_W'(SQ_LAST)) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_init = (iter_r == '0);
        cmd.sqrt_step = (iter_r != '0);
        if (iter_r == ITER_W'(SQRT_LAST)) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (st.len_zero) begin
          cmd.skip  = 1'b1;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_TRAV;
        end
      end
      S_TRAV: begin
        cmd.trav  = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (iter_r == '0);
        if (iter_r == ITER_W'(DIV_LAST)) state_nxt = S_LERP;
      end
      S_LERP: begin
        cmd.lerp = 1'b1;
        if (iter_r == ITER_W'(LERP_LAST)) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHK;
      end
      S_TEND: begin
        cmd.tick_end = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    iter_nxt = (state_nxt != state_r) ? '0 : iter_r + ITER_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

// File: hdl/ppf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_datapath
// Waypoint memory, follower state, segment length by shift-subtract root,
// fraction by restoring division, interpolation and the result register.
// ----------------------------------------------------------------------------
module ppf_datapath import ppf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_point_index,
  input  logic [8:0]         in_point_total,
  input  logic [19:0]        in_delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic               out_following,
  output logic               out_start_ok
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = IW + 1;

  // configuration
  logic [31:0] speed_r;
  logic [30:0] half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 32'd65536;
      half_r  <= 31'd65536;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SPEED) speed_r <= cfg_data;
      else                        half_r  <= cfg_data[30:0];
    end
  end

  // captured item
  cmd_code_t          code_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [7:0]         idx_r;
  logic [8:0]         total_r;
  logic [19:0]        dt_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r  <= cmd_code_t'(in_command);
      cx_r    <= in_coord_x;
      cy_r    <= in_coord_y;
      cz_r    <= in_coord_z;
      idx_r   <= in_point_index;
      total_r <= in_point_total;
      dt_r    <= in_delta_time;
    end
  end

  // follower state
  logic [CW-1:0]      count_r;
  logic [IW-1:0]      seg_r;
  logic [15:0]        frac_r;
  logic               follow_r;
  logic [30:0]        hoff_r;
  logic signed [31:0] held_x_r, held_y_r, held_z_r;
  logic               ok_r;

  // waypoint memory, x y z packed in one word
  logic [95:0]   mem [MAX_POINTS];
  logic [95:0]   rd_r;
  logic [IW+7:0] idx_ext;
  logic [IW-1:0] rd_addr;
  logic          idx_ok;

  assign idx_ext = {{IW{1'b0}}, idx_r};
  assign idx_ok  = (idx_ext < (IW+8)'(MAX_POINTS));

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_seg)       rd_addr = seg_r;
    else if (cmd.rd_seg1) rd_addr = seg_r + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && idx_ok) mem[idx_ext[IW-1:0]] <= {cx_r, cy_r, cz_r};
    rd_r <= mem[rd_addr];
  end

  logic signed [31:0] rd_x, rd_y, rd_z;
  assign rd_x = rd_r[95:64];
  assign rd_y = rd_r[63:32];
  assign rd_z = rd_r[31:0];

  // start
  logic [CW+8:0]      tot_ext;
  logic [CW-1:0]      tot_sat;
  logic signed [32:0] hd;
  logic [32:0]        hd_mag;

  assign tot_ext = {{CW{1'b0}}, total_r};
  assign tot_sat = (tot_ext > (CW+9)'(MAX_POINTS)) ? CW'(MAX_POINTS) : tot_ext[CW-1:0];
  assign hd      = 33'(cy_r) - 33'(rd_y);
  assign hd_mag  = hd[32] ? 33'(-hd) : 33'(hd);

  // tick walk registers
  logic [35:0]        should_r, moved_r;
  logic signed [31:0] ax_r, ay_r, az_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [64:0]        sq_r;
  logic [65:0]        sum_r;
  logic [71:0]        rad_r;
  logic [39:0]        rem_r;
  logic [35:0]        root_r;
  logic [33:0]        len;
  logic [33:0]        trav_r, step_r;
  logic [34:0]        drem_r;
  logic [16:0]        alpha_r;
  logic signed [50:0] prod_r;

  assign len = root_r[33:0];

  logic [SW-1:0] seg_next;
  assign seg_next = SW'(seg_r) + SW'(1);

  // squaring: magnitude never exceeds 2^32, so the top bit alone gives 2^64
  logic signed [32:0] dsel;
  logic [32:0]        dmag;
  logic [64:0]        sq_val;

  always_comb begin
    case (cmd.iter[1:0])
      2'd0:    dsel = dx_r;
      2'd1:    dsel = dy_r;
      default: dsel = dz_r;
    endcase
    dmag   = dsel[32] ? 33'(-dsel) : 33'(dsel);
    sq_val = dmag[32] ? {1'b1, 64'd0} : {1'b0, 64'(dmag[31:0]) * 64'(dmag[31:0])};
  end

  // square root step
  logic [39:0] rem_sh, trial;
  assign rem_sh = {rem_r[37:0], rad_r[71:70]};
  assign trial  = {2'b00, root_r, 2'b01};

  // division step
  logic [34:0] dcmp;
  logic        dbit;
  assign dcmp = cmd.div_first ? drem_r : {drem_r[33:0], 1'b0};
  assign dbit = (dcmp >= 35'(len));

  // step selection
  logic [33:0] left;
  logic [35:0] need;
  assign left = len - trav_r;
  assign need = should_r - moved_r;

  // interpolation
  logic signed [32:0] lsel;
  logic signed [31:0] asel;
  logic signed [34:0] lq, lres;
  logic signed [35:0] ysum;

  always_comb begin
    case (cmd.iter[1:0])
      2'd0:    lsel = dx_r;
      2'd1:    lsel = dy_r;
      default: lsel = dz_r;
    endcase
    case (cmd.iter[1:0])
      2'd1:    asel = ax_r;
      2'd2:    asel = ay_r;
      default: asel = az_r;
    endcase
    lq   = 35'(prod_r >>> 16);
    lres = 35'(asel) + lq;
    ysum = 36'(lres) + $signed({5'd0, hoff_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_init) begin
      should_r <= 36'((52'(speed_r) * 52'(dt_r)) >> 16);
      moved_r  <= '0;
    end
    if (cmd.cap_a) begin
      ax_r <= rd_x;
      ay_r <= rd_y;
      az_r <= rd_z;
    end
    if (cmd.diff) begin
      dx_r  <= 33'(rd_x) - 33'(ax_r);
      dy_r  <= 33'(rd_y) - 33'(ay_r);
      dz_r  <= 33'(rd_z) - 33'(az_r);
      sum_r <= '0;
    end
    if (cmd.sq_en) begin
      if (cmd.iter[1:0] != 2'd3) sq_r  <= sq_val;
      if (cmd.iter[1:0] != 2'd0) sum_r <= sum_r + 66'(sq_r);
    end
    if (cmd.sqrt_init) begin
      rad_r  <= {6'd0, sum_r};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[69:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[34:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[34:0], 1'b0};
      end
    end
    if (cmd.trav) trav_r <= 34'((50'(len) * 50'(frac_r)) >> 16);
    if (cmd.step) step_r <= (36'(left) > need) ? need[33:0] : left;
    if (cmd.div_init) begin
      moved_r <= moved_r + 36'(step_r);
      drem_r  <= 35'(trav_r) + 35'(step_r);
    end
    if (cmd.div_step) begin
      drem_r  <= dbit ? dcmp - 35'(len) : dcmp;
      alpha_r <= {alpha_r[15:0], dbit};
    end
    if (cmd.lerp && cmd.iter[1:0] != 2'd3) begin
      prod_r <= 51'(lsel * $signed({1'b0, alpha_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      seg_r    <= '0;
      frac_r   <= '0;
      follow_r <= 1'b0;
      hoff_r   <= '0;
      held_x_r <= '0;
      held_y_r <= '0;
      held_z_r <= '0;
      ok_r     <= 1'b0;
    end else begin
      if (cmd.clr_ok) ok_r <= 1'b0;
      if (cmd.start_set) begin
        count_r  <= tot_sat;
        seg_r    <= '0;
        frac_r   <= '0;
        follow_r <= 1'b1;
        held_x_r <= cx_r;
        held_y_r <= cy_r;
        held_z_r <= cz_r;
        hoff_r   <= (hd_mag > 33'(half_r)) ? half_r : hd_mag[30:0];
        ok_r     <= 1'b1;
      end
      if (cmd.stop) follow_r <= 1'b0;
      if (cmd.skip) begin
        seg_r  <= seg_r + IW'(1);
        frac_r <= '0;
      end
      if (cmd.lerp) begin
        case (cmd.iter[1:0])
          2'd1: held_x_r <= lres[31:0];
          2'd2: held_y_r <= (ysum > 36'sd2147483647) ? 32'sh7fffffff : ysum[31:0];
          2'd3: held_z_r <= lres[31:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        if (alpha_r >= SNAP_LIMIT) begin
          seg_r  <= seg_r + IW'(1);
          frac_r <= '0;
        end else begin
          frac_r <= alpha_r[15:0];
        end
      end
      if (cmd.tick_end && !(seg_next < SW'(count_r))) follow_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_x     <= held_x_r;
      out_pos_y     <= held_y_r;
      out_pos_z     <= held_z_r;
      out_following <= follow_r;
      out_start_ok  <= ok_r;
    end
  end

  assign st.code       = code_r;
  assign st.total_zero = (total_r == '0);
  assign st.follow     = follow_r;
  assign st.go         = (moved_r < should_r) && (seg_next < SW'(count_r));
  assign st.len_zero   = (len == '0);
  assign st.out_free   = !out_valid || !out_stall;

endmodule

// File: hdl/polyline_path_follower_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_path_follower_unit
// Follows a stored polyline of 3-D waypoints along its arc length.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one command per transfer: load a
// waypoint, start following, tick, or stop. Each command yields exactly one
// result transfer on out_valid / out_stall carrying the held position, the
// following flag and start_ok.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 speed,
// index 1 half_height; write only while the block is idle.
// Load, stop and a tick while not following go straight to the result
// register; start with a nonzero total first reads waypoint 0. A following
// tick walks the segments one at a time through the shared sequencer:
// squares, square root and, for a nonzero length, 17-step division and
// interpolation. The next item is taken in the cycle after the result load.
// One item is worked at a time; the next item is taken while the previous
// result still waits in the output register, and a stalled receiver holds
// the result and stops the block only when the next result is ready.
// Reset clears the follower state and the output valid; the waypoint
// memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module polyline_path_follower_unit import ppf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_point_index,
  input  logic [8:0]         in_point_total,
  input  logic [19:0]        in_delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic               out_following,
  output logic               out_start_ok
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  ppf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ppf_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_command),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_point_index (in_point_index),
    .in_point_total (in_point_total),
    .in_delta_time  (in_delta_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_following  (out_following),
    .out_start_ok   (out_start_ok)
  );

endmodule
